@@ rtl/fsp_pkg.sv @@
// Package: shared types, character codes and type-letter decode for the format spec parser.
`timescale 1ns / 1ps
`default_nettype none
package fsp_pkg;

	typedef enum logic [3:0] {
		PH_SIGN  = 4'd0,
		PH_HASH  = 4'd1,
		PH_ZERO  = 4'd2,
		PH_WIDTH = 4'd3,
		PH_DOT   = 4'd4,
		PH_PREC  = 4'd5,
		PH_LOC   = 4'd6,
		PH_TYPE  = 4'd7,
		PH_DONE  = 4'd8
	} phase_t;

	localparam logic [1:0] ALIGN_NONE   = 2'd0;
	localparam logic [1:0] ALIGN_LEFT   = 2'd1;
	localparam logic [1:0] ALIGN_RIGHT  = 2'd2;
	localparam logic [1:0] ALIGN_CENTER = 2'd3;

	localparam logic [1:0] SIGN_NONE  = 2'd0;
	localparam logic [1:0] SIGN_SPACE = 2'd1;
	localparam logic [1:0] SIGN_PLUS  = 2'd2;
	localparam logic [1:0] SIGN_MINUS = 2'd3;

	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_LOCALE = 8'h4C;

	localparam logic [4:0] TYPE_NONE = 5'd0;

	// Parse status apart from the two numbers, whose width is a top-level parameter.
	typedef struct packed {
		phase_t      phase;
		logic [7:0]  fill_char;
		logic [1:0]  align;
		logic [1:0]  sign_mode;
		logic        alt_form;
		logic        zero_pad;
		logic        width_given;
		logic        prec_given;
		logic        locale_flag;
		logic [4:0]  type_code;
		logic        parse_error;
	} status_t;

	typedef struct packed {
		logic [7:0]  fill_char;
		logic [1:0]  align;
		logic [1:0]  sign_mode;
		logic        alt_form;
		logic        zero_pad;
		logic        width_given;
		logic [15:0] width_value;
		logic        prec_given;
		logic [15:0] prec_value;
		logic        locale_flag;
		logic [4:0]  type_code;
		logic        parse_error;
	} result_t;

	function automatic logic [4:0] type_lookup(input logic [7:0] c);
		logic [4:0] code;
		unique case (c)
			"?": code = 5'd1;
			"b": code = 5'd2;
			"B": code = 5'd3;
			"c": code = 5'd4;
			"d": code = 5'd5;
			"o": code = 5'd6;
			"x": code = 5'd7;
			"X": code = 5'd8;
			"a": code = 5'd9;
			"A": code = 5'd10;
			"e": code = 5'd11;
			"E": code = 5'd12;
			"f": code = 5'd13;
			"F": code = 5'd14;
			"g": code = 5'd15;
			"G": code = 5'd16;
			"p": code = 5'd17;
			"P": code = 5'd18;
			default: code = TYPE_NONE;
		endcase
		return code;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

endpackage
`default_nettype wire

@@ rtl/fsp_in_if.sv @@
// Interface: character word channel into the parser.
`timescale 1ns / 1ps
`default_nettype none
interface fsp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       last;

	modport source (output valid, ch, last, input ready);
	modport sink (input valid, ch, last, output ready);
endinterface
`default_nettype wire

@@ rtl/fsp_out_if.sv @@
// Interface: parsed result word channel out of the parser.
`timescale 1ns / 1ps
`default_nettype none
interface fsp_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  fill_char;
	logic [1:0]  align;
	logic [1:0]  sign_mode;
	logic        alt_form;
	logic        zero_pad;
	logic        width_given;
	logic [15:0] width_value;
	logic        prec_given;
	logic [15:0] prec_value;
	logic        locale_flag;
	logic [4:0]  type_code;
	logic        parse_error;

	modport source (
		output valid, fill_char, align, sign_mode, alt_form, zero_pad, width_given,
		width_value, prec_given, prec_value, locale_flag, type_code, parse_error,
		input ready
	);
	modport sink (
		input valid, fill_char, align, sign_mode, alt_form, zero_pad, width_given,
		width_value, prec_given, prec_value, locale_flag, type_code, parse_error,
		output ready
	);
endinterface
`default_nettype wire

@@ rtl/fsp_feed.sv @@
// Combinational step: applies one character to the parse status and numbers.
`timescale 1ns / 1ps
`default_nettype none
module fsp_feed
	import fsp_pkg::*;
#(
	parameter int NUM_MAX_BITS = 16
) (
	input  status_t                  base,
	input  logic [NUM_MAX_BITS-1:0]  base_w,
	input  logic [NUM_MAX_BITS-1:0]  base_p,
	input  logic [7:0]               ch,
	output status_t                  nxt,
	output logic [NUM_MAX_BITS-1:0]  nxt_w,
	output logic [NUM_MAX_BITS-1:0]  nxt_p
);

	localparam int N = NUM_MAX_BITS;

	// v*10 + d, clamped to all ones
	function automatic logic [N-1:0] acc10(input logic [N-1:0] v, input logic [3:0] d);
		logic [N+3:0] s;
		s = ({4'b0, v} << 3) + ({4'b0, v} << 1) + (N+4)'(d);
		return (|s[N+3:N]) ? {N{1'b1}} : s[N-1:0];
	endfunction

	logic       go;
	logic       dig;
	logic [4:0] tcode;

	assign dig   = is_digit(ch);
	assign tcode = type_lookup(ch);

	// Phases fall through in order until one of them consumes the character.
	always_comb begin
		nxt   = base;
		nxt_w = base_w;
		nxt_p = base_p;
		go    = 1'b1;
		if (nxt.phase == PH_SIGN) begin
			nxt.phase = PH_HASH;
			if (ch == CH_SPACE) begin
				nxt.sign_mode = SIGN_SPACE;
				go = 1'b0;
			end else if (ch == CH_PLUS) begin
				nxt.sign_mode = SIGN_PLUS;
				go = 1'b0;
			end else if (ch == CH_MINUS) begin
				nxt.sign_mode = SIGN_MINUS;
				go = 1'b0;
			end
		end
		if (go && nxt.phase == PH_HASH) begin
			nxt.phase = PH_ZERO;
			if (ch == CH_HASH) begin
				nxt.alt_form = 1'b1;
				go = 1'b0;
			end
		end
		if (go && nxt.phase == PH_ZERO) begin
			nxt.phase = PH_WIDTH;
			if (ch == CH_ZERO) begin
				nxt.zero_pad = 1'b1;
				go = 1'b0;
			end
		end
		if (go && nxt.phase == PH_WIDTH) begin
			if (dig) begin
				nxt.width_given = 1'b1;
				nxt_w = acc10(base_w, ch[3:0]);
				go = 1'b0;
			end else begin
				nxt.phase = PH_DOT;
			end
		end
		if (go && nxt.phase == PH_DOT) begin
			if (ch == CH_DOT) begin
				nxt.phase = PH_PREC;
				go = 1'b0;
			end else begin
				nxt.phase = PH_LOC;
			end
		end
		if (go && nxt.phase == PH_PREC) begin
			if (dig) begin
				nxt.prec_given = 1'b1;
				nxt_p = acc10(base_p, ch[3:0]);
				go = 1'b0;
			end else begin
				nxt.phase = PH_LOC;
			end
		end
		if (go && nxt.phase == PH_LOC) begin
			nxt.phase = PH_TYPE;
			if (ch == CH_LOCALE) begin
				nxt.locale_flag = 1'b1;
				go = 1'b0;
			end
		end
		if (go && nxt.phase == PH_TYPE) begin
			nxt.phase = PH_DONE;
			if (tcode != TYPE_NONE) begin
				nxt.type_code = tcode;
			end else begin
				nxt.parse_error = 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/fsp_core.sv @@
// Parse state registers: held first character, lookahead for fill/align, result build.
`timescale 1ns / 1ps
`default_nettype none
module fsp_core
	import fsp_pkg::*;
#(
	parameter int NUM_MAX_BITS = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    acc,
	input  logic [7:0] ch,
	input  logic    last,
	output logic    push,
	output result_t res
);

	localparam int N  = NUM_MAX_BITS;
	localparam int EW = (N > 16) ? N : 16;

	status_t         st_q;
	logic [N-1:0]    w_q;
	logic [N-1:0]    p_q;
	logic [7:0]      held_q;
	logic            pending_q;
	logic            started_q;

	status_t         base;
	logic [N-1:0]    base_w;
	logic [N-1:0]    base_p;
	status_t         fed;
	logic [N-1:0]    fed_w;
	logic [N-1:0]    fed_p;
	status_t         nxt;
	logic [N-1:0]    nxt_w;
	logic [N-1:0]    nxt_p;
	logic            is_align;
	logic [EW-1:0]   w_ext;
	logic [EW-1:0]   p_ext;

	// Before the first character the step starts from the cleared status. The first
	// character is fed speculatively; if the second one is an alignment mark that is
	// thrown away and the first becomes the fill.
	assign base   = started_q ? st_q : status_t'('0);
	assign base_w = started_q ? w_q : '0;
	assign base_p = started_q ? p_q : '0;

	fsp_feed #(.NUM_MAX_BITS(N)) u_feed (
		.base   (base),
		.base_w (base_w),
		.base_p (base_p),
		.ch     (ch),
		.nxt    (fed),
		.nxt_w  (fed_w),
		.nxt_p  (fed_p)
	);

	assign is_align = (ch == CH_LT) || (ch == CH_GT) || (ch == CH_CARET);

	always_comb begin
		nxt   = fed;
		nxt_w = fed_w;
		nxt_p = fed_p;
		if (pending_q && is_align) begin
			nxt           = status_t'('0);
			nxt.fill_char = held_q;
			if (ch == CH_LT) begin
				nxt.align = ALIGN_LEFT;
			end else if (ch == CH_GT) begin
				nxt.align = ALIGN_RIGHT;
			end else begin
				nxt.align = ALIGN_CENTER;
			end
			nxt_w = '0;
			nxt_p = '0;
		end
	end

	assign push  = acc && last;
	assign w_ext = EW'(nxt_w);
	assign p_ext = EW'(nxt_p);

	always_comb begin
		res.fill_char   = nxt.fill_char;
		res.align       = nxt.align;
		res.sign_mode   = nxt.sign_mode;
		res.alt_form    = nxt.alt_form;
		res.zero_pad    = nxt.zero_pad;
		res.width_given = nxt.width_given;
		res.width_value = w_ext[15:0];
		res.prec_given  = nxt.prec_given;
		res.prec_value  = p_ext[15:0];
		res.locale_flag = nxt.locale_flag;
		res.type_code   = nxt.type_code;
		res.parse_error = nxt.parse_error;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= status_t'('0);
			w_q       <= '0;
			p_q       <= '0;
			held_q    <= '0;
			pending_q <= 1'b0;
			started_q <= 1'b0;
		end else if (acc) begin
			if (last) begin
				st_q      <= status_t'('0);
				w_q       <= '0;
				p_q       <= '0;
				pending_q <= 1'b0;
				started_q <= 1'b0;
			end else begin
				st_q      <= nxt;
				w_q       <= nxt_w;
				p_q       <= nxt_p;
				pending_q <= !started_q;
				started_q <= 1'b1;
				if (!started_q) begin
					held_q <= ch;
				end
			end
		end
	end

	a_pending_started: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q |-> started_q)
		else $error("held first character without a started spec");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && last) |=> (!started_q && !pending_q))
		else $error("parse state not cleared after final character");

	a_spec_advanced: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q |-> (st_q.phase != PH_SIGN))
		else $error("speculative first-character step did not advance phase");

endmodule
`default_nettype wire

@@ rtl/fsp_obuf.sv @@
// Two-entry result queue between the parse step and the output channel.
`timescale 1ns / 1ps
`default_nettype none
module fsp_obuf
	import fsp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t din,
	output logic    can_take,
	output logic    dout_valid,
	input  logic    dout_ready,
	output result_t dout
);

	result_t e0_q;
	result_t e1_q;
	logic    v0_q;
	logic    v1_q;
	logic    pop;

	assign pop        = v0_q && dout_ready;
	assign can_take   = !v1_q;
	assign dout_valid = v0_q;
	assign dout       = e0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v0_q <= 1'b0;
			v1_q <= 1'b0;
		end else begin
			if (pop) begin
				if (v1_q) begin
					v1_q <= 1'b0;
				end else begin
					v0_q <= push;
				end
			end else if (push) begin
				if (v0_q) begin
					v1_q <= 1'b1;
				end else begin
					v0_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (v1_q) begin
				e0_q <= e1_q;
			end else if (push) begin
				e0_q <= din;
			end
		end else if (push) begin
			if (v0_q) begin
				e1_q <= din;
			end else begin
				e0_q <= din;
			end
		end
	end

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		v1_q |-> v0_q)
		else $error("second queue entry valid while head empty");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !v1_q)
		else $error("result pushed into full queue");

endmodule
`default_nettype wire

@@ rtl/format_spec_parser.sv @@
// Top level: format spec parser, one character word per ready cycle, one result per spec.
// The parser takes a format specification one character word at a time on "spec",
// the word with last=1 ending it, and returns one result word on "result" holding
// fill/alignment, sign mode, alternate form, zero pad, width, precision, locale flag
// and type code (parse_error set and type_code 0 for an unknown type letter).
// A character is accepted every cycle while "spec.ready" is high; each one goes
// through a single short decode step between the state registers and the result
// queue; the final character's result is written into the queue and goes out on
// "result" behind any results already waiting. Results wait in a two-entry queue,
// so input keeps flowing with one result pending; ready drops only when two results
// are unclaimed. Width and precision saturate at 2^NUM_MAX_BITS-1 and are reported
// as their low 16 bits. Characters after the type letter are ignored until the final one.
`timescale 1ns / 1ps
`default_nettype none
module format_spec_parser
	import fsp_pkg::*;
#(
	parameter int NUM_MAX_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	fsp_in_if.sink        spec,
	fsp_out_if.source     result
);

	logic    acc;
	logic    push;
	logic    can_take;
	result_t res;
	result_t res_out;

	// word accepted on the input side
	assign spec.ready = can_take;
	assign acc        = spec.valid && can_take;

	fsp_core #(.NUM_MAX_BITS(NUM_MAX_BITS)) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.acc    (acc),
		.ch     (spec.ch),
		.last   (spec.last),
		.push   (push),
		.res    (res)
	);

	fsp_obuf u_obuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.din        (res),
		.can_take   (can_take),
		.dout_valid (result.valid),
		.dout_ready (result.ready),
		.dout       (res_out)
	);

	assign result.fill_char   = res_out.fill_char;
	assign result.align       = res_out.align;
	assign result.sign_mode   = res_out.sign_mode;
	assign result.alt_form    = res_out.alt_form;
	assign result.zero_pad    = res_out.zero_pad;
	assign result.width_given = res_out.width_given;
	assign result.width_value = res_out.width_value;
	assign result.prec_given  = res_out.prec_given;
	assign result.prec_value  = res_out.prec_value;
	assign result.locale_flag = res_out.locale_flag;
	assign result.type_code   = res_out.type_code;
	assign result.parse_error = res_out.parse_error;

endmodule
`default_nettype wire

@@ tb/format_spec_parser_tb.sv @@
// Testbench for the format specification parser: directed, random and back-pressure runs.
`timescale 1ns / 1ps
`default_nettype none
module format_spec_parser_tb;
	import fsp_pkg::*;

	// Width of the digit accumulators inside the block; reported values keep 16 bits.
	localparam int NUM_BITS = 16;
	localparam longint unsigned NUM_MAX = (64'd1 << NUM_BITS) - 64'd1;
	// Type letters in code order: position 0 is code 1.
	localparam int NUM_TYPES = 18;
	localparam logic [8*NUM_TYPES-1:0] TYPE_LETTERS = "?bBcdoxXaAeEfFgGpP";
	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_PRINTED = 40;

	logic clk = 1'b0;
	logic arst_n;

	fsp_in_if  spec_if ();
	fsp_out_if res_if ();

	format_spec_parser #(
		.NUM_MAX_BITS(NUM_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.spec(spec_if),
		.result(res_if)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Idle limits for each side, changed by the tests between phases.
	int tx_max;
	int rx_max;
	// Long receiver hold-off: the test bumps hold_seq, the sink picks it up.
	int hold_seq;
	int hold_len;

	int mismatches;
	int chars_sent;
	int specs_sent;
	int results_seen;
	int error_results;
	int saturated_results;
	longint unsigned cycles;

	// Predictor state: parse position, held first character and fields so far.
	phase_t          ph;
	logic [7:0]      held_ch;
	logic            held_valid;
	result_t         cur;
	longint unsigned width_acc;
	longint unsigned prec_acc;
	logic            err_seen;

	// Parsed specifications still owed by the block, oldest first.
	result_t    parsed_specs[$];
	// Characters of the specification being built for sending.
	logic [7:0] spec_buf[$];

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	task automatic clear_parse();
		ph = PH_SIGN;
		held_ch = 8'h00;
		held_valid = 1'b0;
		cur = '0;
		width_acc = 0;
		prec_acc = 0;
		err_seen = 1'b0;
	endtask

	function automatic logic [7:0] type_letter(input int idx);
		return TYPE_LETTERS[8*(NUM_TYPES-1-idx) +: 8];
	endfunction

	function automatic longint unsigned add_digit(input longint unsigned acc,
			input logic [7:0] c);
		longint unsigned v;
		v = acc * 10 + longint'(c - CH_ZERO);
		return (v > NUM_MAX) ? NUM_MAX : v;
	endfunction

	// One character through the field sequence. A field that does not match
	// hands the character on to the next one, within the same call.
	function automatic void feed_char(input logic [7:0] c);
		logic go;
		go = 1'b1;
		while (go) begin
			case (ph)
				PH_SIGN: begin
					ph = PH_HASH;
					if (c == CH_SPACE) begin
						cur.sign_mode = SIGN_SPACE;
						go = 1'b0;
					end else if (c == CH_PLUS) begin
						cur.sign_mode = SIGN_PLUS;
						go = 1'b0;
					end else if (c == CH_MINUS) begin
						cur.sign_mode = SIGN_MINUS;
						go = 1'b0;
					end
				end
				PH_HASH: begin
					ph = PH_ZERO;
					if (c == CH_HASH) begin
						cur.alt_form = 1'b1;
						go = 1'b0;
					end
				end
				PH_ZERO: begin
					ph = PH_WIDTH;
					if (c == CH_ZERO) begin
						cur.zero_pad = 1'b1;
						go = 1'b0;
					end
				end
				PH_WIDTH: begin
					if (c >= CH_ZERO && c <= CH_NINE) begin
						cur.width_given = 1'b1;
						width_acc = add_digit(width_acc, c);
						go = 1'b0;
					end else
						ph = PH_DOT;
				end
				PH_DOT: begin
					// no dot: straight on to the locale check
					if (c == CH_DOT) begin
						ph = PH_PREC;
						go = 1'b0;
					end else
						ph = PH_LOC;
				end
				PH_PREC: begin
					if (c >= CH_ZERO && c <= CH_NINE) begin
						cur.prec_given = 1'b1;
						prec_acc = add_digit(prec_acc, c);
						go = 1'b0;
					end else
						ph = PH_LOC;
				end
				PH_LOC: begin
					ph = PH_TYPE;
					if (c == CH_LOCALE) begin
						cur.locale_flag = 1'b1;
						go = 1'b0;
					end
				end
				PH_TYPE: begin
					ph = PH_DONE;
					err_seen = 1'b1;
					for (int i = 0; i < NUM_TYPES; i++)
						if (type_letter(i) == c) begin
							cur.type_code = 5'(i + 1);
							err_seen = 1'b0;
						end
					go = 1'b0;
				end
				default: go = 1'b0;  // done: ignore until the last word
			endcase
		end
	endfunction

	// Predict for one accepted character word.
	task automatic parse_char(input logic [7:0] c, input logic l);
		result_t r;
		logic started;
		started = held_valid || (ph != PH_SIGN) || (cur.align != ALIGN_NONE);
		if (!started) begin
			// first word: hold it until we know whether it is a fill character
			held_ch = c;
			held_valid = 1'b1;
		end else if (held_valid) begin
			held_valid = 1'b0;
			if (c == CH_LT || c == CH_GT || c == CH_CARET) begin
				cur.fill_char = held_ch;
				cur.align = (c == CH_LT) ? ALIGN_LEFT :
					(c == CH_GT) ? ALIGN_RIGHT : ALIGN_CENTER;
			end else begin
				feed_char(held_ch);
				feed_char(c);
			end
		end else
			feed_char(c);

		if (l) begin
			// single-character spec: the held word is parsed on its own
			if (held_valid) begin
				held_valid = 1'b0;
				feed_char(held_ch);
			end
			r = cur;
			r.width_value = width_acc[15:0];
			r.prec_value = prec_acc[15:0];
			r.type_code = err_seen ? TYPE_NONE : cur.type_code;
			r.parse_error = err_seen;
			parsed_specs.push_back(r);
			clear_parse();
		end
	endtask

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------

	task automatic report_mismatch(input string msg);
		if (mismatches < MAX_PRINTED)
			$display("[%0t] MISMATCH result %0d: %s", $time, results_seen, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input longint unsigned got,
			input longint unsigned want);
		if (got != want)
			report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
	endtask

	// Outputs sampled at the edge, before the block's updates land.
	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (parsed_specs.size() == 0)
				report_mismatch("result word with nothing outstanding");
			else begin
				want = parsed_specs.pop_front();
				check_field("fill_char", res_if.fill_char, want.fill_char);
				check_field("align", res_if.align, want.align);
				check_field("sign_mode", res_if.sign_mode, want.sign_mode);
				check_field("alt_form", res_if.alt_form, want.alt_form);
				check_field("zero_pad", res_if.zero_pad, want.zero_pad);
				check_field("width_given", res_if.width_given, want.width_given);
				check_field("width_value", res_if.width_value, want.width_value);
				check_field("prec_given", res_if.prec_given, want.prec_given);
				check_field("prec_value", res_if.prec_value, want.prec_value);
				check_field("locale_flag", res_if.locale_flag, want.locale_flag);
				check_field("type_code", res_if.type_code, want.type_code);
				check_field("parse_error", res_if.parse_error, want.parse_error);
				if (want.parse_error)
					error_results++;
				if (want.width_value == 16'hFFFF || want.prec_value == 16'hFFFF)
					saturated_results++;
			end
			results_seen++;
		end
	end

	// Result sink: random stall per word, plus the occasional long hold-off.
	initial begin : result_sink
		int gap;
		int wait_left;
		int hold_left;
		int hold_seen;
		res_if.ready = 1'b0;
		wait_left = 0;
		hold_left = 0;
		hold_seen = 0;
		forever begin
			@(posedge clk);
			if (!arst_n)
				res_if.ready <= 1'b0;
			else if (hold_seq != hold_seen) begin
				hold_seen = hold_seq;
				hold_left = hold_len;
				res_if.ready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left--;
				res_if.ready <= 1'b0;
			end else if (res_if.valid && res_if.ready) begin
				gap = $urandom_range(0, rx_max);
				wait_left = gap;
				res_if.ready <= (gap == 0);
			end else if (wait_left != 0) begin
				wait_left--;
				res_if.ready <= (wait_left == 0);
			end else
				res_if.ready <= 1'b1;
		end
	end

	// Watchdog: well above the slowest legal run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding",
				cycles, parsed_specs.size());
			$display("format_spec_parser verification failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	// Offer one character word; valid stays high across back-to-back words.
	task automatic send_char(input logic [7:0] c, input logic l);
		int gap;
		gap = $urandom_range(0, tx_max);
		if (gap != 0) begin
			spec_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		spec_if.valid <= 1'b1;
		spec_if.ch <= c;
		spec_if.last <= l;
		@(posedge clk);
		while (!spec_if.ready)
			@(posedge clk);
		parse_char(c, l);
		chars_sent++;
	endtask

	task automatic send_spec();
		for (int i = 0; i < spec_buf.size(); i++)
			send_char(spec_buf[i], i == spec_buf.size() - 1);
		spec_buf.delete();
		specs_sent++;
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			spec_buf.push_back(s[i]);
	endtask

	task automatic add_digits(input int n);
		repeat (n)
			spec_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
	endtask

	task automatic add_noise(input int n);
		repeat (n)
			spec_buf.push_back(8'($urandom_range(0, 255)));
	endtask

	function automatic int digit_count();
		// mostly short numbers, now and then long enough to saturate
		return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 3);
	endfunction

	// Mostly well-formed specs with random content; the rest raw noise.
	task automatic build_random_spec();
		int r;
		if ($urandom_range(0, 99) < 12) begin
			add_noise($urandom_range(1, 8));
			return;
		end
		if ($urandom_range(0, 2) == 0) begin
			add_noise(1);
			case ($urandom_range(0, 2))
				0: spec_buf.push_back(CH_LT);
				1: spec_buf.push_back(CH_GT);
				default: spec_buf.push_back(CH_CARET);
			endcase
		end
		if ($urandom_range(0, 1) == 0)
			case ($urandom_range(0, 2))
				0: spec_buf.push_back(CH_SPACE);
				1: spec_buf.push_back(CH_PLUS);
				default: spec_buf.push_back(CH_MINUS);
			endcase
		if ($urandom_range(0, 2) == 0)
			spec_buf.push_back(CH_HASH);
		if ($urandom_range(0, 2) == 0)
			spec_buf.push_back(CH_ZERO);
		if ($urandom_range(0, 1) == 0)
			add_digits(digit_count());
		if ($urandom_range(0, 2) == 0) begin
			spec_buf.push_back(CH_DOT);
			if ($urandom_range(0, 3) != 0)
				add_digits(digit_count());
		end
		if ($urandom_range(0, 3) == 0)
			spec_buf.push_back(CH_LOCALE);
		r = $urandom_range(0, 9);
		if (r == 1)
			add_noise(1);
		else if (r != 0 || spec_buf.size() == 0)
			spec_buf.push_back(type_letter($urandom_range(0, NUM_TYPES - 1)));
		// trailing characters after the type are ignored by the parser
		if ($urandom_range(0, 7) == 0)
			add_noise($urandom_range(1, 3));
	endtask

	// Stop offering words, then wait until every predicted result is back.
	task automatic wait_drained();
		spec_if.valid <= 1'b0;
		while (parsed_specs.size() != 0)
			@(posedge clk);
	endtask

	// Field extremes and the corner cases of the grammar, one spec each.
	task automatic test_directed();
		tx_max = 3;
		rx_max = 3;
		add_text("?");                       // lone type letter
		send_spec();
		spec_buf.push_back(8'h00);           // zero byte in type position
		send_spec();
		spec_buf.push_back(8'hFF);           // high byte in type position
		send_spec();
		spec_buf.push_back(8'hFF);           // high byte as fill, nothing after
		spec_buf.push_back(CH_LT);
		send_spec();
		spec_buf.push_back(CH_LT);           // alignment without fill is an error
		send_spec();
		add_text("9.");                      // dot with no precision digits
		send_spec();
		add_text(" #0x");
		send_spec();
		add_text("0^");                      // zero as fill, center
		send_spec();
		add_text("x>+7.2LGz");               // fill/align, sign, width, precision, locale, type, then ignored junk
		send_spec();
		wait_drained();
	endtask

	// Bulk random specs; idle limits flip between phases so some runs are gap-free.
	task automatic test_random(input int target_chars);
		int stop_at;
		int n;
		stop_at = chars_sent + target_chars;
		n = 0;
		while (chars_sent < stop_at) begin
			if (n % 40 == 0) begin
				case ($urandom_range(0, 3))
					0: begin tx_max = 0; rx_max = 0; end
					1: begin tx_max = 15; rx_max = 15; end
					2: begin tx_max = 0; rx_max = 15; end
					default: begin tx_max = 15; rx_max = 0; end
				endcase
			end
			build_random_spec();
			send_spec();
			n++;
		end
		wait_drained();
	endtask

	// Receiver holds off while short specs stream in, so the result queue
	// fills and the input stalls; then the sender waits for the drain.
	task automatic test_backpressure();
		for (int round = 0; round < 2; round++) begin
			tx_max = 0;
			rx_max = 0;
			hold_len = 120;
			hold_seq++;
			repeat (10) begin
				if ($urandom_range(0, 1) == 0)
					spec_buf.push_back(type_letter($urandom_range(0, NUM_TYPES - 1)));
				else
					build_random_spec();
				send_spec();
			end
			wait_drained();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		spec_if.valid = 1'b0;
		spec_if.ch = 8'h00;
		spec_if.last = 1'b0;
		tx_max = 0;
		rx_max = 0;
		hold_seq = 0;
		hold_len = 0;
		mismatches = 0;
		chars_sent = 0;
		specs_sent = 0;
		results_seen = 0;
		error_results = 0;
		saturated_results = 0;
		cycles = 0;
		clear_parse();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_backpressure();
		test_random(860);
		test_backpressure();

		wait_drained();
		// results leave through a registered queue; allow some slack
		repeat (20) @(posedge clk);

		$display("Sent %0d specs in %0d character words; checked %0d results",
			specs_sent, chars_sent, results_seen);
		$display("  %0d with unknown type, %0d with a saturated number, %0d mismatches",
			error_results, saturated_results, mismatches);
		if (mismatches == 0 && parsed_specs.size() == 0)
			$display("format_spec_parser verification clean");
		else
			$display("format_spec_parser verification failed");
		$finish;
	end

endmodule
`default_nettype wire
